// ----- hdl/assert_macros.svh -----
// assertion macros shared by the texel fetch decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after its trigger
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tfd_pkg.sv -----
// types, constants and helper functions of the texel fetch decoder
`timescale 1ns / 1ps

package tfd_pkg;

    // store and coordinate geometry
    localparam int STORE_ADDR_BITS = 16;
    localparam int SIDE_BITS       = 10;
    localparam int PIX_W           = 10;
    localparam int ROW_W           = 11;
    localparam int PROD_W          = PIX_W + ROW_W;
    localparam int TW_W            = 2 * SIDE_BITS;
    localparam int ADDR_W          = (TW_W + 3 > 26) ? (TW_W + 3) : 26;
    localparam logic [ADDR_W-1:0] STORE_SIZE = ADDR_W'(1) << STORE_ADDR_BITS;
    localparam logic [ADDR_W-1:0] STORE_LAST = STORE_SIZE - ADDR_W'(1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT     = 3'd0,
        CFG_LAYOUT_MODE      = 3'd1,
        CFG_ROW_WIDTH        = 3'd2,
        CFG_PIXEL_BASE       = 3'd3,
        CFG_CODEBOOK_BASE    = 3'd4,
        CFG_CODEBOOK_ENTRIES = 3'd5
    } t_cfg_idx;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // texel encodings
    localparam logic [1:0] FMT_ARGB1555 = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_ARGB4444 = 2'd2;

    // addressing layouts
    localparam logic [1:0] LAY_LINEAR  = 2'd0;
    localparam logic [1:0] LAY_TWIDDLE = 2'd1;
    localparam logic [1:0] LAY_VQ      = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;

    // fetch sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_INDEX,
        S_TEXEL
    } t_state;

    // result request from the sequencer to the output stage
    typedef struct packed {
        logic       load;
        logic [1:0] status;
        logic [1:0] fmt;
    } t_res_req;

    // morton interleave, x bits in odd positions
    function automatic logic [TW_W-1:0] interleave(input logic [PIX_W-1:0] x,
                                                   input logic [PIX_W-1:0] y);
        logic [TW_W-1:0] r;
        r = '0;
        for (int b = 0; b < SIDE_BITS; b++) begin
            if (b < PIX_W) begin
                r[2*b+1] = x[b];
                r[2*b]   = y[b];
            end
        end
        return r;
    endfunction

    // v*255/31 rounded down: 8v plus floor(7v/31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0] n;
        logic [2:0] q;
        n = ({3'b0, v} << 3) - {3'b0, v};
        q = '0;
        for (int k = 1; k <= 7; k++) begin
            if (n >= 8'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {v, 3'b0} + {5'b0, q};
    endfunction

    // v*255/63 rounded down: 4v plus floor(3v/63)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [7:0] n;
        logic [1:0] q;
        n = ({2'b0, v} << 1) + {2'b0, v};
        q = '0;
        for (int k = 1; k <= 3; k++) begin
            if (n >= 8'(63 * k)) begin
                q = q + 2'd1;
            end
        end
        return {v, 2'b0} + {6'b0, q};
    endfunction

endpackage

// ----- hdl/tfd_in_if.sv -----
// input channel: store writes and pixel fetches
`timescale 1ns / 1ps

interface tfd_in_if
    import tfd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [15:0]      store_address;
    logic [7:0]       byte_value;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;

    modport source (output valid, cmd, store_address, byte_value, pixel_x, pixel_y,
                    input ready);
    modport sink   (input valid, cmd, store_address, byte_value, pixel_x, pixel_y,
                    output ready);
endinterface

// ----- hdl/tfd_out_if.sv -----
// output channel: decoded pixel colour and status
`timescale 1ns / 1ps

interface tfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;

    modport source (output valid, red, green, blue, alpha, status, input ready);
    modport sink   (input valid, red, green, blue, alpha, status, output ready);
endinterface

// ----- hdl/texture_texel_fetch_decoder.sv -----
// Texel fetch decoder: store writes are accepted while idle and return no beat.
// A fetch steps through the address, index (VQ only) and texel states, as set
// by the dependent reads of the registered store memory: address, index byte
// read, texel read. The texel state loads the result beat once the output
// register is free; no item is accepted until idle. Synchronous active-low reset
// clears the sequencer, output valid flag and configuration; the store is not.
`timescale 1ns / 1ps

module texture_texel_fetch_decoder
    import tfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tfd_in_if.sink                i_item,
    tfd_out_if.source             o_result
);

    `include "assert_macros.svh"

    // configuration registers
    logic [1:0]       r_pixel_format;
    logic [1:0]       r_layout_mode;
    logic [ROW_W-1:0] r_row_width;
    logic [15:0]      r_pixel_base;
    logic [15:0]      r_codebook_base;
    logic [8:0]       r_codebook_entries;

    // sequencer state
    t_state              r_state, n_state;
    logic [PIX_W-1:0]    r_x, r_y;
    logic [PROD_W-1:0]   r_prod;
    logic [1:0]          r_err, n_err;

    // store ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [7:0]        rdata_a, rdata_b;

    // address datapath
    logic [PROD_W:0]   lin_off;
    logic [ADDR_W-1:0] lin_addr, tw_addr, vq_ia, pix_addr, tex_addr;
    logic              in_acc, fetch_acc, out_free;
    logic              ia_bad, pix_bad, idx_bad, tex_bad;
    t_res_req          res_req;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format     <= FMT_ARGB1555;
            r_layout_mode      <= LAY_LINEAR;
            r_row_width        <= ROW_W'(1);
            r_pixel_base       <= '0;
            r_codebook_base    <= '0;
            r_codebook_entries <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_FORMAT:     r_pixel_format     <= i_cfg_data[1:0];
                CFG_LAYOUT_MODE:      r_layout_mode      <= i_cfg_data[1:0];
                CFG_ROW_WIDTH:        r_row_width        <= i_cfg_data[ROW_W-1:0];
                CFG_PIXEL_BASE:       r_pixel_base       <= i_cfg_data;
                CFG_CODEBOOK_BASE:    r_codebook_base    <= i_cfg_data;
                CFG_CODEBOOK_ENTRIES: r_codebook_entries <= i_cfg_data[8:0];
                default:              r_pixel_format     <= r_pixel_format;
            endcase
        end
    end

    // handshake
    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && i_item.ready;
    assign fetch_acc    = in_acc && (i_item.cmd == CMD_FETCH);
    assign wr_addr      = ADDR_W'(i_item.store_address);
    assign ram_we       = in_acc && (i_item.cmd == CMD_WRITE) && (wr_addr < STORE_SIZE);

    // texel and index addresses from the captured pixel
    assign lin_off  = (PROD_W+1)'(r_prod) + (PROD_W+1)'(r_x);
    assign lin_addr = ADDR_W'(r_pixel_base) + ADDR_W'({lin_off, 1'b0});
    assign tw_addr  = ADDR_W'(r_pixel_base) + ADDR_W'({interleave(r_x, r_y), 1'b0});
    assign vq_ia    = ADDR_W'(r_pixel_base)
                    + ADDR_W'(interleave({1'b0, r_x[PIX_W-1:1]}, {1'b0, r_y[PIX_W-1:1]}));
    assign pix_addr = (r_layout_mode == LAY_TWIDDLE) ? tw_addr : lin_addr;
    assign tex_addr = ADDR_W'(r_codebook_base) + ADDR_W'({rdata_a, 3'b0})
                    + ADDR_W'({r_x[0], r_y[0], 1'b0});
    assign ia_bad   = (vq_ia >= STORE_SIZE);
    assign pix_bad  = (pix_addr >= STORE_LAST);
    assign idx_bad  = ({1'b0, rdata_a} >= r_codebook_entries);
    assign tex_bad  = (tex_addr >= STORE_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (fetch_acc) n_state = S_ADDR;
            S_ADDR: begin
                if (r_layout_mode == LAY_VQ && !ia_bad) begin
                    n_state = S_INDEX;
                end else begin
                    n_state = S_TEXEL;
                end
            end
            S_INDEX: n_state = S_TEXEL;
            S_TEXEL: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // read issue, status and result request
    always_comb begin
        ram_re         = 1'b0;
        rd_addr_a      = pix_addr;
        rd_addr_b      = pix_addr + ADDR_W'(1);
        n_err          = r_err;
        res_req.load   = 1'b0;
        res_req.status = r_err;
        res_req.fmt    = r_pixel_format;
        unique case (r_state)
            S_IDLE: n_err = STAT_OK;
            S_ADDR: begin
                if (r_layout_mode == LAY_VQ) begin
                    rd_addr_a = vq_ia;
                    if (ia_bad) begin
                        n_err = STAT_RANGE;
                    end else begin
                        ram_re = 1'b1;
                    end
                end else if (pix_bad) begin
                    n_err = STAT_RANGE;
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_INDEX: begin
                rd_addr_a = tex_addr;
                rd_addr_b = tex_addr + ADDR_W'(1);
                if (idx_bad) begin
                    n_err = STAT_BAD_INDEX;
                end else if (tex_bad) begin
                    n_err = STAT_RANGE;
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_TEXEL: res_req.load = out_free;
            default: n_err = r_err;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // fetch context
    always_ff @(posedge i_clk) begin
        r_err <= n_err;
        if (fetch_acc) begin
            r_x    <= i_item.pixel_x;
            r_y    <= i_item.pixel_y;
            r_prod <= PROD_W'({{ROW_W{1'b0}}, i_item.pixel_y} * {{PIX_W{1'b0}}, r_row_width});
        end
    end

    tfd_store_ram #(
        .ADDR_BITS (STORE_ADDR_BITS),
        .DATA_BITS (8)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (wr_addr[STORE_ADDR_BITS-1:0]),
        .i_wdata   (i_item.byte_value),
        .i_re      (ram_re),
        .i_raddr_a (rd_addr_a[STORE_ADDR_BITS-1:0]),
        .i_raddr_b (rd_addr_b[STORE_ADDR_BITS-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    tfd_texel_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (res_req),
        .i_lo     (rdata_a),
        .i_hi     (rdata_b),
        .o_free   (out_free),
        .o_result (o_result)
    );

    `TFD_ASSERT(a_no_rw_clash, i_clk, i_rst_n, !(ram_we && ram_re), "store read during write")
    `TFD_ASSERT_NEXT(a_fetch_to_addr, i_clk, i_rst_n, fetch_acc, r_state == S_ADDR, "fetch did not start")
    `TFD_ASSERT(a_index_after_addr, i_clk, i_rst_n, r_state != S_INDEX || $past(r_state) == S_ADDR, "index state out of order")

endmodule

// ----- hdl/tfd_store_ram.sv -----
// byte store: one write port, two registered read ports
`timescale 1ns / 1ps

module tfd_store_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr_a,
    input  logic [ADDR_BITS-1:0] i_raddr_b,
    output logic [DATA_BITS-1:0] o_rdata_a,
    output logic [DATA_BITS-1:0] o_rdata_b
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ----- hdl/tfd_texel_expand.sv -----
// texel expansion to rgba8 and the output register
`timescale 1ns / 1ps

module tfd_texel_expand
    import tfd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_res_req      i_req,
    input  logic [7:0]    i_lo,
    input  logic [7:0]    i_hi,
    output logic          o_free,
    tfd_out_if.source     o_result
);

    `include "assert_macros.svh"

    logic        r_valid;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    logic [1:0]  r_status;
    logic [7:0]  n_red, n_green, n_blue, n_alpha;
    logic [15:0] texel;

    assign texel  = {i_hi, i_lo};
    assign o_free = !r_valid || o_result.ready;

    // colour expansion, zero on error or unused format
    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_alpha = '0;
        if (i_req.status == STAT_OK) begin
            case (i_req.fmt)
                FMT_ARGB1555: begin
                    n_red   = expand5(texel[14:10]);
                    n_green = expand5(texel[9:5]);
                    n_blue  = expand5(texel[4:0]);
                    n_alpha = texel[15] ? 8'hFF : 8'h00;
                end
                FMT_RGB565: begin
                    n_red   = expand5(texel[15:11]);
                    n_green = expand6(texel[10:5]);
                    n_blue  = expand5(texel[4:0]);
                    n_alpha = 8'hFF;
                end
                FMT_ARGB4444: begin
                    n_red   = {texel[11:8], texel[11:8]};
                    n_green = {texel[7:4], texel[7:4]};
                    n_blue  = {texel[3:0], texel[3:0]};
                    n_alpha = {texel[15:12], texel[15:12]};
                end
                default: begin
                    n_red = '0;
                end
            endcase
        end
    end

    // output beat valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_alpha  <= n_alpha;
            r_status <= i_req.status;
        end
    end

    assign o_result.valid  = r_valid;
    assign o_result.red    = r_red;
    assign o_result.green  = r_green;
    assign o_result.blue   = r_blue;
    assign o_result.alpha  = r_alpha;
    assign o_result.status = r_status;

    `TFD_ASSERT(a_load_when_free, i_clk, i_rst_n, !i_req.load || o_free, "load into busy output")
    `TFD_ASSERT(a_err_zero, i_clk, i_rst_n, !(r_valid && r_status != STAT_OK) || ({r_red, r_green, r_blue, r_alpha} == 32'd0), "error beat with colour")

endmodule
